### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the modular exponentiation RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, reset values and sequencer states of the exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int FIELD_BITS = 63;
  localparam int OPERAND_BITS_DEF = 63;

  localparam logic [FIELD_BITS-1:0] MODULUS_RESET = 63'd1000000007;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR
  } state_t;

endpackage

### sv/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Right-to-left square and multiply on one shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// The bit-serial multiplier works on N = OPERAND_BITS bit operands and runs one
// product for the base reduction, one per exponent bit for squaring and one
// per set bit of the exponent for multiply.
// One beat at a time, the next one accepted in the strobe cycle; the receiver cannot stall.
// A zero modulus strobes 0 right after the accepting edge. Sync reset sets modulus 1000000007.
`include "assert_macros.svh"

module modular_exponentiation #(
  parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [modexp_pkg::FIELD_BITS-1:0] in_base_value,
  input  logic [modexp_pkg::FIELD_BITS-1:0] in_exponent_value,
  output logic                            out_valid,
  output logic [modexp_pkg::FIELD_BITS-1:0] out_power_result,
  input  logic                            cfg_we,
  input  logic [modexp_pkg::FIELD_BITS-1:0] cfg_wdata
);

  localparam int N  = OPERAND_BITS;
  localparam int FW = modexp_pkg::FIELD_BITS;
  localparam int CW = $clog2(N);

  modexp_pkg::state_t state_r, state_nxt;

  logic [FW-1:0] cfg_mod_r;
  logic [N-1:0]  m_r, m_nxt;
  logic [N-1:0]  x_r, x_nxt;
  logic [N-1:0]  acc_r, acc_nxt;
  logic [N-1:0]  y_r, y_nxt;
  logic [N-1:0]  ma_r, ma_nxt;
  logic [N-1:0]  mb_r, mb_nxt;
  logic [N-1:0]  macc_r, macc_nxt;
  logic [CW-1:0] mcnt_r, mcnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] result_r, result_nxt;

  logic [N:0]    dbl, dbl_red, sum, sum_red;
  logic [N-1:0]  macc_step;
  logic [N-1:0]  m_in, one_mod;
  logic [N-1:0]  x_dec, acc_dec, y_dec;
  logic          go_next;

  always_comb begin
    dbl       = {macc_r, 1'b0};
    dbl_red   = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    sum       = {1'b0, dbl_red[N-1:0]} + {1'b0, mb_r};
    sum_red   = (sum >= {1'b0, m_r}) ? sum - {1'b0, m_r} : sum;
    macc_step = ma_r[N-1] ? sum_red[N-1:0] : dbl_red[N-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    x_nxt         = x_r;
    acc_nxt       = acc_r;
    y_nxt         = y_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    macc_nxt      = macc_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = 1'b0;
    result_nxt    = result_r;
    go_next       = 1'b0;
    x_dec         = x_r;
    acc_dec       = acc_r;
    y_dec         = y_r;
    m_in          = cfg_mod_r[N-1:0];
    one_mod       = (m_in == N'(1)) ? '0 : N'(1);

    case (state_r)
      modexp_pkg::ST_IDLE: begin
        if (start) begin
          m_nxt = m_in;
          if (m_in == '0) begin
            out_valid_nxt = 1'b1;
            result_nxt    = '0;
          end else begin
            state_nxt = modexp_pkg::ST_REDUCE;
            ma_nxt    = in_base_value[N-1:0];
            mb_nxt    = one_mod;
            acc_nxt   = one_mod;
            y_nxt     = in_exponent_value[N-1:0];
            macc_nxt  = '0;
            mcnt_nxt  = CW'(N - 1);
          end
        end
      end
      modexp_pkg::ST_REDUCE, modexp_pkg::ST_MUL, modexp_pkg::ST_SQR: begin
        ma_nxt   = ma_r << 1;
        macc_nxt = macc_step;
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          go_next = 1'b1;
          if (state_r == modexp_pkg::ST_MUL) begin
            acc_dec = macc_step;
          end else begin
            x_dec = macc_step;
          end
          if (state_r == modexp_pkg::ST_SQR) begin
            y_dec = y_r >> 1;
          end
        end
      end
      default: begin
        state_nxt = modexp_pkg::ST_IDLE;
      end
    endcase

    if (go_next) begin
      x_nxt    = x_dec;
      acc_nxt  = acc_dec;
      y_nxt    = y_dec;
      macc_nxt = '0;
      mcnt_nxt = CW'(N - 1);
      if (state_r == modexp_pkg::ST_MUL) begin
        state_nxt = modexp_pkg::ST_SQR;
        ma_nxt    = x_dec;
        mb_nxt    = x_dec;
      end else if (y_dec == '0) begin
        state_nxt     = modexp_pkg::ST_IDLE;
        mcnt_nxt      = '0;
        out_valid_nxt = 1'b1;
        result_nxt    = FW'(acc_dec);
      end else if (y_dec[0]) begin
        state_nxt = modexp_pkg::ST_MUL;
        ma_nxt    = acc_dec;
        mb_nxt    = x_dec;
      end else begin
        state_nxt = modexp_pkg::ST_SQR;
        ma_nxt    = x_dec;
        mb_nxt    = x_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= modexp_pkg::ST_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_mod_r   <= modexp_pkg::MODULUS_RESET;
    end else begin
      state_r     <= state_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_mod_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    m_r      <= m_nxt;
    x_r      <= x_nxt;
    acc_r    <= acc_nxt;
    y_r      <= y_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    macc_r   <= macc_nxt;
    result_r <= result_nxt;
  end

  assign busy             = (state_r != modexp_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = result_r;

  `ASSERT_CLK(a_result_below_mod, out_valid |-> ((m_r == '0) ? (out_power_result == '0) : (out_power_result < FW'(m_r))), "result not reduced below the modulus")
  `ASSERT_CLK(a_start_takes_effect, (start && !busy) |=> (busy || out_valid), "accepted beat had no effect")
  `ASSERT_CLK(a_idle_counter_clear, (state_r == modexp_pkg::ST_IDLE) |-> (mcnt_r == '0), "multiplier counter running while idle")
  `ASSERT_CLK(a_exponent_left, (state_r == modexp_pkg::ST_MUL || state_r == modexp_pkg::ST_SQR) |-> (y_r != '0), "product started with no exponent bits left")

endmodule
